/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Clock is clk, reset is rst (active high).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ccii_pkg.sv */
// ----------------------------------------------------------------------------
// ccii_pkg
// Types and constants for the calibration curve inverse interpolator.
// ----------------------------------------------------------------------------
package ccii_pkg;

  // Item kinds
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DEGEN   = 2'd1;
  localparam logic [1:0] ST_WRITTEN = 2'd2;

  // Configuration register indexes
  localparam logic REG_FEEDBACK = 1'b0;
  localparam logic REG_ROWS     = 1'b1;

  localparam logic [23:0] FEEDBACK_RESET = 24'd10000;
  localparam logic [4:0]  ROWS_RESET     = 5'd16;

  // mV (Q15.8) * 1000 -> uA (Q16.16): scale by 1000 * 256
  localparam logic [31:0] CUR_SCALE = 32'd256000;

  // Quotient clamp for the segment step
  localparam logic [63:0] QUOT_CLAMP = 64'h0000_0100_0000_0000;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CW    = 7;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CUR_MUL,
    S_CUR_DIVGO,
    S_CUR_DIV,
    S_RD0,
    S_RD1,
    S_RDL,
    S_CHK,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_SEG_RA,
    S_SEG_RB,
    S_SEG_DIFF,
    S_SEG_MAG,
    S_SEG_MUL,
    S_SEG_DIVGO,
    S_SEG_DIV,
    S_FINISH
  } state_t;

endpackage

/* src/ccii_div.sv */
// ----------------------------------------------------------------------------
// ccii_div
// Radix-2 restoring unsigned divider, 64-bit dividend by 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccii_div (
  input  logic              clk,
  input  logic              rst,
  input  ccii_pkg::div_req_t req,
  output ccii_pkg::div_rsp_t rsp
);
  import ccii_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [31:0]       rem;
  logic [63:0]       quo;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_sub;

  assign rem_sh  = {rem, quo[63]};
  assign rem_sub = rem_sh - {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      // keep remainder if subtract borrows
      if (!rem_sub[32]) begin
        rem <= rem_sub[31:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/calibration_curve_inverse_interp_top.sv */
// ----------------------------------------------------------------------------
// calibration_curve_inverse_interp_top
// Gas-sensor calibration: loads calibration rows and converts voltage samples
// to concentration by inverse piecewise-linear interpolation over the table.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, func, row_index,       | into block
//          | row_concentration, row_current,           |
//          | sample_millivolts                         |
//  out     | out_valid/out_ready, concentration,       | out of block
//          | status                                    |
//  cfg     | cfg_write, cfg_index, cfg_data            | into block
//
//  A write transaction goes from accept straight to the finish state. A
//  convert transaction makes two passes through the shared radix-2 divider,
//  only the first when the current is on the wrong side of zero or the
//  segment is flat, and its length also grows with each row visited by the
//  segment search.
//  One transaction is in work at a time; in_ready is high only when idle.
//  The finished result sits in the output register, so a stalled out_ready
//  holds only the final step. Reset (synchronous) clears control and config;
//  the table itself has no reset and a row must be written before it is used.
// ----------------------------------------------------------------------------
module calibration_curve_inverse_interp_top #(
  parameter int TABLE_ROWS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [3:0]         row_index,
  input  logic signed [31:0] row_concentration,
  input  logic signed [31:0] row_current,
  input  logic signed [23:0] sample_millivolts,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] concentration,
  output logic [1:0]         status,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);
  import ccii_pkg::*;

  localparam int AW = $clog2(TABLE_ROWS);
  localparam logic [8:0] ROWS_MAX = 9'(TABLE_ROWS);

  // Configuration registers
  logic [23:0] feedback_resistance;
  logic [4:0]  rows_in_use;

  // Sequencer
  state_t state, state_next;

  // Calibration table: {concentration, current} per row
  logic [63:0] table_mem [TABLE_ROWS];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr;

  // Shared multiplier and divider
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Working registers
  logic               mv_neg;
  logic [23:0]        mv_mag;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      k;
  logic [AW-1:0]      seg_a;
  logic signed [31:0] cur;
  logic signed [31:0] cur0;
  logic               rising;
  logic signed [31:0] conc_a;
  logic signed [31:0] cur_a;
  logic signed [32:0] di, dx, dc;
  logic [31:0]        mag_di, mag_dx, mag_dc;
  logic               seg_neg;
  logic signed [31:0] rslt_conc;
  logic [1:0]         rslt_status;

  // Combinational helpers
  logic               in_fire;
  logic               out_load;
  logic [8:0]         row_ext;
  logic               row_ok;
  logic [8:0]         rows_ext;
  logic [8:0]         rows_clamped;
  logic [8:0]         last_full;
  logic [23:0]        res_eff;
  logic [23:0]        mv_abs;
  logic signed [31:0] rd_cur;
  logic signed [31:0] rd_conc;
  logic               wrong_side;
  logic               past_row;
  logic [63:0]        quot;
  logic signed [31:0] cur_sat;
  logic [40:0]        q_clamped;
  logic signed [41:0] seg_sum;
  logic signed [31:0] seg_sat;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  assign row_ext = {5'b0, row_index};
  assign row_ok  = row_ext < ROWS_MAX;

  // Clamp the row count into [2, TABLE_ROWS]
  assign rows_ext     = {4'b0, rows_in_use};
  assign rows_clamped = (rows_ext < 9'd2) ? 9'd2 :
                        (rows_ext > ROWS_MAX) ? ROWS_MAX : rows_ext;
  assign last_full    = rows_clamped - 9'd1;

  // Zero resistance acts as one ohm
  assign res_eff = (feedback_resistance == '0) ? 24'd1 : feedback_resistance;
  assign mv_abs  = sample_millivolts[23] ? $unsigned(~sample_millivolts + 24'sd1)
                                         : $unsigned(sample_millivolts);

  assign rd_cur  = $signed(rd_data[31:0]);
  assign rd_conc = $signed(rd_data[63:32]);

  // Direction-dependent compares against the current in rd_data
  assign wrong_side = rising ? (cur <= 32'sd0) : (cur >= 32'sd0);
  assign past_row   = rising ? (cur >= rd_cur) : (cur <= rd_cur);

  assign quot = div_rsp.quotient;

  // Current from the first division: apply sign, saturate to 32 bits
  always_comb begin
    if (!mv_neg) begin
      cur_sat = (quot > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
    end else begin
      cur_sat = (quot > 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                 : $signed(-quot[31:0]);
    end
  end

  // Segment value from the second division: clamp, add base, saturate
  assign q_clamped = (quot > QUOT_CLAMP) ? QUOT_CLAMP[40:0] : quot[40:0];
  assign seg_sum   = 42'(conc_a) + (seg_neg ? -$signed({1'b0, q_clamped})
                                            : $signed({1'b0, q_clamped}));
  always_comb begin
    if (seg_sum > 42'sh0_7FFF_FFFF) begin
      seg_sat = 32'sh7FFF_FFFF;
    end else if (seg_sum < -42'sh0_8000_0000) begin
      seg_sat = 32'sh8000_0000;
    end else begin
      seg_sat = seg_sum[31:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_resistance <= FEEDBACK_RESET;
      rows_in_use         <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FEEDBACK: feedback_resistance <= cfg_data;
        REG_ROWS:     rows_in_use         <= cfg_data[4:0];
        default:      ;
      endcase
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (func == FUNC_WRITE) && row_ok) begin
      table_mem[row_ext[AW-1:0]] <= {row_concentration, row_current};
    end
    rd_data <= table_mem[rd_addr];
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  ccii_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (func == FUNC_WRITE) ? S_FINISH : S_CUR_MUL;
        end
      end
      S_CUR_MUL:   state_next = S_CUR_DIVGO;
      S_CUR_DIVGO: state_next = S_CUR_DIV;
      S_CUR_DIV:   if (div_rsp.done) state_next = S_RD0;
      S_RD0:       state_next = S_RD1;
      S_RD1:       state_next = S_RDL;
      S_RDL:       state_next = S_CHK;
      S_CHK: begin
        if (wrong_side) begin
          state_next = S_FINISH;
        end else if (past_row) begin
          state_next = S_SEG_RA;
        end else begin
          state_next = S_SRCH_ADDR;
        end
      end
      S_SRCH_ADDR: state_next = (k == last_idx) ? S_SEG_RA : S_SRCH_CMP;
      S_SRCH_CMP:  state_next = past_row ? S_SRCH_ADDR : S_SEG_RA;
      S_SEG_RA:    state_next = S_SEG_RB;
      S_SEG_RB:    state_next = S_SEG_DIFF;
      S_SEG_DIFF:  state_next = S_SEG_MAG;
      S_SEG_MAG:   state_next = (di == '0) ? S_FINISH : S_SEG_MUL;
      S_SEG_MUL:   state_next = S_SEG_DIVGO;
      S_SEG_DIVGO: state_next = S_SEG_DIV;
      S_SEG_DIV:   if (div_rsp.done) state_next = S_FINISH;
      S_FINISH:    if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: read address, shared unit operands, ready
  always_comb begin
    in_ready         = (state == S_IDLE);
    rd_addr          = '0;
    mul_a            = {8'b0, mv_mag};
    mul_b            = CUR_SCALE;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = {8'b0, res_eff};
    case (state)
      S_CUR_DIVGO: div_req.start = 1'b1;
      S_RD1:       rd_addr = AW'(1);
      S_RDL:       rd_addr = last_idx;
      S_SRCH_ADDR: rd_addr = k;
      S_SEG_RA:    rd_addr = seg_a;
      S_SEG_RB:    rd_addr = seg_a + AW'(1);
      S_SEG_MUL: begin
        mul_a = mag_dx;
        mul_b = mag_dc;
      end
      S_SEG_DIVGO: begin
        div_req.start   = 1'b1;
        div_req.divisor = mag_di;
      end
      S_SEG_DIV:   div_req.divisor = mag_di;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, advanced per state
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          mv_neg      <= sample_millivolts[23];
          mv_mag      <= mv_abs;
          last_idx    <= last_full[AW-1:0];
          rslt_conc   <= '0;
          rslt_status <= (func == FUNC_WRITE) ? ST_WRITTEN : ST_OK;
        end
      end
      S_CUR_DIV: begin
        if (div_rsp.done) cur <= cur_sat;
      end
      S_RD1: cur0 <= rd_cur;
      S_RDL: rising <= rd_cur > cur0;
      S_CHK: begin
        k <= '0;
        if (!wrong_side && past_row) seg_a <= last_idx - AW'(1);
      end
      S_SRCH_ADDR: begin
        if (k == last_idx) seg_a <= k - AW'(1);
      end
      S_SRCH_CMP: begin
        if (past_row) begin
          k <= k + AW'(1);
        end else begin
          // current below the first row: use the first segment
          seg_a <= (k == '0) ? '0 : k - AW'(1);
        end
      end
      S_SEG_RB: begin
        conc_a <= rd_conc;
        cur_a  <= rd_cur;
      end
      S_SEG_DIFF: begin
        di <= 33'(rd_cur) - 33'(cur_a);
        dx <= 33'(cur) - 33'(cur_a);
        dc <= 33'(rd_conc) - 33'(conc_a);
      end
      S_SEG_MAG: begin
        mag_di  <= di[32] ? 32'(-di) : di[31:0];
        mag_dx  <= dx[32] ? 32'(-dx) : dx[31:0];
        mag_dc  <= dc[32] ? 32'(-dc) : dc[31:0];
        seg_neg <= (dx[32] != dc[32]) != di[32];
        if (di == '0) rslt_status <= ST_DEGEN;
      end
      S_SEG_DIV: begin
        if (div_rsp.done) rslt_conc <= seg_sat;
      end
      default: ;
    endcase
  end

  // Output register: load when finished and the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      concentration <= rslt_conc;
      status        <= rslt_status;
    end
  end

endmodule

/* src/ccii_chk.sv */
// ----------------------------------------------------------------------------
// ccii_chk
// Port-level checks for the calibration curve inverse interpolator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccii_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] concentration,
  input logic [1:0]         status
);
  import ccii_pkg::*;

  // One transaction at a time: ready drops right after an accept
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted while busy")

  // Writes and degenerate segments report zero concentration
  `ASSERT_IMPLIES(a_zero_conc, out_valid && (status != ST_OK), concentration == 32'sd0, "nonzero concentration with non-ok status")

  // Only defined status codes appear
  `ASSERT_IMPLIES(a_status_code, out_valid, (status == ST_OK) || (status == ST_DEGEN) || (status == ST_WRITTEN), "undefined status code")

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(concentration) && $stable(status), "stalled result changed")

endmodule

bind calibration_curve_inverse_interp_top ccii_chk u_ccii_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .concentration (concentration),
  .status        (status)
);
